/* src/fhc_pkg.sv */
// Shared types and constants for the frame header hunt and checksum receiver.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package fhc_pkg;

  // APB register map, one 32-bit word per register
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] REG_HEADER_CODE  = 2'd0;
  localparam logic [1:0] REG_FRAME_LENGTH = 2'd1;
  localparam logic [1:0] REG_SKIP_LIMIT   = 2'd2;

  // Register reset values
  localparam logic [7:0]  HEADER_CODE_RST  = 8'd0;
  localparam logic [7:0]  FRAME_LENGTH_RST = 8'd31;
  localparam logic [15:0] SKIP_LIMIT_RST   = 16'd1000;

  // Shortest frame: header plus two trailer bytes
  localparam logic [7:0]  FRAME_LEN_MIN    = 8'd3;
  localparam logic [15:0] SKIP_COUNT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  header_code;
    logic [7:0]  frame_length;
    logic [15:0] skip_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       last_byte;
    logic       header_matched;
    logic       checksum_ok;
  } res_t;

endpackage

`default_nettype wire

/* src/fhc_cfg_regs.sv */
// APB configuration registers: header code, frame length and skip limit.
// Depends on fhc_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module fhc_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [fhc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [fhc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [fhc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready,
  output fhc_pkg::cfg_t                           cfg_o
);

  logic [7:0]  header_code_q;
  logic [7:0]  frame_length_q;
  logic [15:0] skip_limit_q;
  logic        wr_en;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_code_q  <= fhc_pkg::HEADER_CODE_RST;
      frame_length_q <= fhc_pkg::FRAME_LENGTH_RST;
      skip_limit_q   <= fhc_pkg::SKIP_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        fhc_pkg::REG_HEADER_CODE:  header_code_q  <= pwdata[7:0];
        fhc_pkg::REG_FRAME_LENGTH: frame_length_q <= pwdata[7:0];
        fhc_pkg::REG_SKIP_LIMIT:   skip_limit_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      fhc_pkg::REG_HEADER_CODE:  prdata = {24'd0, header_code_q};
      fhc_pkg::REG_FRAME_LENGTH: prdata = {24'd0, frame_length_q};
      fhc_pkg::REG_SKIP_LIMIT:   prdata = {16'd0, skip_limit_q};
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.header_code  = header_code_q;
  assign cfg_o.frame_length = frame_length_q;
  assign cfg_o.skip_limit   = skip_limit_q;

endmodule

`default_nettype wire

/* src/fhc_frame_core.sv */
// Frame state: header hunt, byte counting, running sum and trailer compare.
// Depends on fhc_pkg for cfg_t, res_t and the length and count limits.
`timescale 1ns / 1ps
`default_nettype none

module fhc_frame_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    byte_i,
  input  wire fhc_pkg::cfg_t cfg_i,
  output logic               res_valid_o,
  output fhc_pkg::res_t      res_o
);

  logic        collecting_q, collecting_d;
  logic [15:0] skipped_count_q, skipped_count_d;
  logic [7:0]  byte_count_q, byte_count_d;
  logic [15:0] running_sum_q, running_sum_d;
  logic [7:0]  trailer_high_q, trailer_high_d;
  logic        start_matched_q, start_matched_d;

  logic [7:0]  len;
  logic [7:0]  len_m1;
  logic [7:0]  len_m2;
  logic        hit;
  logic [15:0] skip_inc;
  logic        skip_force;

  assign len        = (cfg_i.frame_length < fhc_pkg::FRAME_LEN_MIN) ?
                      fhc_pkg::FRAME_LEN_MIN : cfg_i.frame_length;
  assign len_m1     = len - 8'd1;
  assign len_m2     = len - 8'd2;
  assign hit        = (byte_i == cfg_i.header_code);
  assign skip_inc   = (skipped_count_q != fhc_pkg::SKIP_COUNT_MAX) ?
                      skipped_count_q + 16'd1 : skipped_count_q;
  assign skip_force = (skip_inc >= cfg_i.skip_limit);

  always_comb begin
    collecting_d    = collecting_q;
    skipped_count_d = skipped_count_q;
    byte_count_d    = byte_count_q;
    running_sum_d   = running_sum_q;
    trailer_high_d  = trailer_high_q;
    start_matched_d = start_matched_q;
    res_valid_o          = 1'b0;
    res_o.data_byte      = byte_i;
    res_o.byte_index     = byte_count_q;
    res_o.last_byte      = 1'b0;
    res_o.header_matched = start_matched_q;
    res_o.checksum_ok    = 1'b0;

    if (!collecting_q) begin
      skipped_count_d = skip_inc;
      if (hit || skip_force) begin
        // open the frame on a match, or force it once the limit is reached
        collecting_d         = 1'b1;
        start_matched_d      = hit;
        skipped_count_d      = '0;
        byte_count_d         = 8'd1;
        running_sum_d        = {8'd0, byte_i};
        res_valid_o          = 1'b1;
        res_o.byte_index     = '0;
        res_o.header_matched = hit;
      end
    end else begin
      res_valid_o = 1'b1;
      if (byte_count_q >= len_m1) begin
        // trailer low byte: compare and re-arm the hunt
        res_o.last_byte   = 1'b1;
        res_o.checksum_ok = ({trailer_high_q, byte_i} == running_sum_q);
        collecting_d      = 1'b0;
        skipped_count_d   = '0;
        byte_count_d      = '0;
      end else begin
        if (byte_count_q == len_m2) begin
          trailer_high_d = byte_i;
        end else begin
          running_sum_d = running_sum_q + {8'd0, byte_i};
        end
        byte_count_d = byte_count_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q    <= 1'b0;
      skipped_count_q <= '0;
      byte_count_q    <= '0;
      running_sum_q   <= '0;
      trailer_high_q  <= '0;
      start_matched_q <= 1'b0;
    end else if (step_i) begin
      collecting_q    <= collecting_d;
      skipped_count_q <= skipped_count_d;
      byte_count_q    <= byte_count_d;
      running_sum_q   <= running_sum_d;
      trailer_high_q  <= trailer_high_d;
      start_matched_q <= start_matched_d;
    end
  end

  // hunting keeps no byte position; a frame in progress keeps no skip count
  a_hunt_no_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !collecting_q |-> (byte_count_q == 8'd0))
    else $error("byte count non-zero while hunting");

  a_frame_no_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    collecting_q |-> (skipped_count_q == 16'd0) && (byte_count_q != 8'd0))
    else $error("skip count or position inconsistent within frame");

  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.last_byte |=> !collecting_q)
    else $error("hunt not re-armed after last byte");

  a_mid_frame_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && !res_o.last_byte |=> collecting_q)
    else $error("frame dropped before its last byte");

  a_ok_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.checksum_ok |-> res_o.last_byte)
    else $error("checksum flag outside last byte");

endmodule

`default_nettype wire

/* src/frame_header_hunt_checksum_receiver.sv */
// Top level of the frame header hunt and checksum receiver.
// Depends on fhc_pkg, fhc_cfg_regs and fhc_frame_core.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel rx: one received byte per transaction on rx_byte_i, taken at
//   a rising edge with rx_valid_i high and rx_stall_o low.
//   Output channel: one frame byte per transaction (data_byte_o, byte_index_o,
//   last_byte_o, header_matched_o, checksum_ok_o), taken with out_valid_o high
//   and out_stall_i low. Bytes discarded while hunting give no transaction.
//   Configuration: APB registers header_code (0x0), frame_length (0x4) and
//   skip_limit (0x8); write only while the block is idle. pready is tied high.
//   A byte passes the input register, then the result register, before its
//   result is presented. Throughput: one byte per cycle while out_stall_i is
//   low, set by the single compare/count/add pass between the two registers.
//   Reset clears the hunt state, the registers to their defaults and both
//   valid flags. When the receiver stalls, the result register holds and one
//   further byte waits in the input register; rx_stall_o then rises until the
//   result is taken.

module frame_header_hunt_checksum_receiver (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [fhc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [fhc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [fhc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready,
  // received bytes
  input  wire logic                               rx_valid_i,
  output logic                                    rx_stall_o,
  input  wire logic [7:0]                         rx_byte_i,
  // frame bytes
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [7:0]                         data_byte_o,
  output logic      [7:0]                         byte_index_o,
  output logic                                    last_byte_o,
  output logic                                    header_matched_o,
  output logic                                    checksum_ok_o
);

  fhc_pkg::cfg_t cfg;
  fhc_pkg::res_t res;
  fhc_pkg::res_t out_q;
  logic          res_valid;

  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          out_valid_q;
  logic          out_ready;
  logic          step;

  fhc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The result register can take a new value when empty or being drained
  assign out_ready  = !out_valid_q || !out_stall_i;
  // Process the held byte whenever the result register can take it
  assign step       = in_valid_q && out_ready;
  // Hold the input register only while its byte cannot move on
  assign rx_stall_o = in_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!rx_stall_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && !rx_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  fhc_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register: load on a produced result, clear on a drained one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_byte_o      = out_q.data_byte;
  assign byte_index_o     = out_q.byte_index;
  assign last_byte_o      = out_q.last_byte;
  assign header_matched_o = out_q.header_matched;
  assign checksum_ok_o    = out_q.checksum_ok;

endmodule

`default_nettype wire
